[src/pcx_pkg.sv]
// shared constants, codes and controller/datapath interface types for the pcx decoder
package pcx_pkg;

   // largest accepted image side
   localparam int MAX_SIDE = 4096;

   // field and counter widths
   localparam int BYTE_W  = 8;
   localparam int POS_W   = 24;
   localparam int DIM_W   = 13;
   localparam int CNT_W   = 25;
   localparam int HDR_W   = 7;
   localparam int RUN_W   = 6;
   localparam int PAL_W   = 10;
   localparam int FULL_W  = 17;
   localparam int RSP_W   = 64;

   // header signature and layout
   localparam logic [BYTE_W-1:0] SIG_B0 = 8'd10;
   localparam logic [BYTE_W-1:0] SIG_B1 = 8'd5;
   localparam logic [BYTE_W-1:0] SIG_B2 = 8'd1;
   localparam logic [BYTE_W-1:0] SIG_B3 = 8'd8;
   localparam logic [HDR_W-1:0]  IDX_SIG0 = 7'd0;
   localparam logic [HDR_W-1:0]  IDX_SIG1 = 7'd1;
   localparam logic [HDR_W-1:0]  IDX_SIG2 = 7'd2;
   localparam logic [HDR_W-1:0]  IDX_SIG3 = 7'd3;
   localparam logic [HDR_W-1:0]  IDX_WLO  = 7'd8;
   localparam logic [HDR_W-1:0]  IDX_WHI  = 7'd9;
   localparam logic [HDR_W-1:0]  IDX_HLO  = 7'd10;
   localparam logic [HDR_W-1:0]  IDX_HHI  = 7'd11;
   localparam logic [HDR_W-1:0]  HDR_LAST = 7'd127;

   // data section codes
   localparam logic [1:0]        RUN_TAG    = 2'b11;
   localparam logic [BYTE_W-1:0] PAL_MARKER = 8'd12;
   localparam logic [PAL_W-1:0]  PAL_LAST   = 10'd767;

   // result kinds
   typedef enum logic [2:0] {
      KIND_PIXEL   = 3'd0,
      KIND_PALETTE = 3'd1,
      KIND_SIZE    = 3'd2,
      KIND_DONE    = 3'd3,
      KIND_ERROR   = 3'd4
   } kind_type;

   // error codes
   typedef enum logic [1:0] {
      ERR_SIGNATURE = 2'd0,
      ERR_SIZE      = 2'd1,
      ERR_MARKER    = 2'd2
   } err_type;

   // controller to datapath commands
   typedef struct packed {
      logic     hdr_step;
      logic     size_load;
      logic     run_arm;
      logic     run_load;
      logic     pix_step;
      logic     pal_clear;
      logic     pal_step;
      logic     out_load;
      logic     out_run;
      logic     out_last;
      kind_type out_kind;
      err_type  out_err;
   } pcx_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic sig_bad;
      logic hdr_dim;
      logic dim_big;
      logic hdr_end;
      logic byte_run;
      logic byte_marker;
      logic run_pending;
      logic run_empty;
      logic run_tail;
      logic pix_end;
      logic pal_end;
   } pcx_status_type;

endpackage

[src/pcx_rle_image_decoder.sv]
// pcx run-length image decoder top level
// Takes an 8-bit PCX file one byte per transfer (start flag in req_tuser marks byte 0)
// and returns image size, pixels in raster order, 768 palette components and a done
// or error result. A run value byte is followed by the pixels of its (clipped) run, up
// to 63, and the last palette byte by the done result; no input is taken meanwhile.
// The single result register paces the decoder: input is taken while that register is
// empty or being drained, and run pixels and the done result are issued from it one per
// cycle while it is free.
module pcx_rle_image_decoder
   import pcx_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // data_byte
   input  logic             req_tuser,   // start_req
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // value[7:0], position[31:8], image_width[44:32],
                                         // image_height[57:45], error_code[59:58], zero
   output logic [2:0]       rsp_tuser,   // result_kind
   output logic             rsp_tlast    // last
);

   pcx_cmd_type    cmd;
   pcx_status_type status;
   kind_type       rsp_kind;

   pcx_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_start  (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pcx_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .data_byte (req_tdata),
      .start_req (req_tuser),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_tdata),
      .rsp_kind  (rsp_kind),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tuser = rsp_kind;

endmodule

[src/pcx_dp.sv]
// pcx decoder datapath: header fields, pixel and palette counters, result register
module pcx_dp
   import pcx_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [BYTE_W-1:0]    data_byte,
   input  logic                 start_req,
   input  pcx_cmd_type          cmd,
   output pcx_status_type       status,
   output logic [RSP_W-1:0]     rsp_data,
   output kind_type             rsp_kind,
   output logic                 rsp_last
);

   logic [HDR_W-1:0]   hdr_cnt_ff;
   logic [DIM_W-1:0]   width_ff;
   logic [DIM_W-1:0]   height_ff;
   logic [CNT_W-1:0]   total_ff;
   logic [CNT_W-1:0]   done_ff;
   logic               run_pend_ff;
   logic [RUN_W-1:0]   run_len_ff;
   logic [RUN_W-1:0]   run_cnt_ff;
   logic [BYTE_W-1:0]  run_val_ff;
   logic [PAL_W-1:0]   pal_cnt_ff;

   kind_type           out_kind_ff;
   err_type            out_err_ff;
   logic               out_last_ff;
   logic [BYTE_W-1:0]  out_value_ff;
   logic [POS_W-1:0]   out_pos_ff;
   logic [DIM_W-1:0]   out_width_ff;
   logic [DIM_W-1:0]   out_height_ff;

   logic [BYTE_W-1:0]  out_value_in;
   logic [POS_W-1:0]   out_pos_in;
   logic [DIM_W-1:0]   out_width_in;
   logic [DIM_W-1:0]   out_height_in;

   logic [HDR_W-1:0]   idx;
   logic [BYTE_W-1:0]  dim_lo;
   logic [FULL_W-1:0]  full;
   logic [2*DIM_W-1:0] product;
   logic [CNT_W-1:0]   left;
   logic [RUN_W-1:0]   run_count;

   // header position, restarted by a start flag
   assign idx = start_req ? '0 : hdr_cnt_ff;

   // dimension assembly: low byte, high byte, plus one
   assign dim_lo  = (idx == IDX_WHI) ? width_ff[BYTE_W-1:0] : height_ff[BYTE_W-1:0];
   assign full    = {1'b0, data_byte, dim_lo} + FULL_W'(1);
   assign product = width_ff * height_ff;

   // run length clipped to the pixels left
   assign left      = total_ff - done_ff;
   assign run_count = (left < CNT_W'(run_len_ff)) ? left[RUN_W-1:0] : run_len_ff;

   // status toward the controller
   always_comb begin
      status.sig_bad     = ((idx == IDX_SIG0) && (data_byte != SIG_B0)) ||
                           ((idx == IDX_SIG1) && (data_byte != SIG_B1)) ||
                           ((idx == IDX_SIG2) && (data_byte != SIG_B2)) ||
                           ((idx == IDX_SIG3) && (data_byte != SIG_B3));
      status.hdr_dim     = (idx == IDX_WHI) || (idx == IDX_HHI);
      status.dim_big     = full > FULL_W'(MAX_SIDE);
      status.hdr_end     = idx == HDR_LAST;
      status.byte_run    = data_byte[BYTE_W-1:BYTE_W-2] == RUN_TAG;
      status.byte_marker = data_byte == PAL_MARKER;
      status.run_pending = run_pend_ff;
      status.run_empty   = run_count == '0;
      status.run_tail    = run_cnt_ff == RUN_W'(1);
      status.pix_end     = (done_ff + CNT_W'(1)) >= total_ff;
      status.pal_end     = pal_cnt_ff == PAL_LAST;
   end

   // result payload selection by kind
   always_comb begin
      out_value_in  = '0;
      out_pos_in    = '0;
      out_width_in  = '0;
      out_height_in = '0;
      case (cmd.out_kind)
         KIND_PIXEL: begin
            out_value_in = cmd.out_run ? run_val_ff : data_byte;
            out_pos_in   = done_ff[POS_W-1:0];
         end
         KIND_PALETTE: begin
            out_value_in = {2'b00, data_byte[BYTE_W-1:2]};
            out_pos_in   = POS_W'(pal_cnt_ff);
         end
         KIND_SIZE: begin
            out_width_in  = width_ff;
            out_height_in = height_ff;
         end
         default: begin
            out_value_in = '0;
         end
      endcase
   end

   // control counters
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_cnt_ff  <= '0;
         run_pend_ff <= 1'b0;
      end else begin
         if (cmd.hdr_step) begin
            hdr_cnt_ff <= idx + HDR_W'(1);
         end
         if (cmd.size_load || cmd.run_load) begin
            run_pend_ff <= 1'b0;
         end else if (cmd.run_arm) begin
            run_pend_ff <= 1'b1;
         end
      end
   end

   // header fields, counters and run registers
   always_ff @(posedge clock) begin
      if (cmd.hdr_step) begin
         if (idx == IDX_WLO) begin
            width_ff <= DIM_W'(data_byte);
         end
         if (idx == IDX_HLO) begin
            height_ff <= DIM_W'(data_byte);
         end
         if (idx == IDX_WHI) begin
            width_ff <= full[DIM_W-1:0];
         end
         if (idx == IDX_HHI) begin
            height_ff <= full[DIM_W-1:0];
         end
      end
      if (cmd.size_load) begin
         total_ff <= product[CNT_W-1:0];
         done_ff  <= '0;
      end else if (cmd.pix_step) begin
         done_ff <= done_ff + CNT_W'(1);
      end
      if (cmd.run_arm) begin
         run_len_ff <= data_byte[RUN_W-1:0];
      end
      if (cmd.run_load) begin
         run_cnt_ff <= run_count;
         run_val_ff <= data_byte;
      end else if (cmd.pix_step && cmd.out_run) begin
         run_cnt_ff <= run_cnt_ff - RUN_W'(1);
      end
      if (cmd.pal_clear) begin
         pal_cnt_ff <= '0;
      end else if (cmd.pal_step) begin
         pal_cnt_ff <= pal_cnt_ff + PAL_W'(1);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_kind_ff   <= cmd.out_kind;
         out_err_ff    <= cmd.out_err;
         out_last_ff   <= cmd.out_last;
         out_value_ff  <= out_value_in;
         out_pos_ff    <= out_pos_in;
         out_width_ff  <= out_width_in;
         out_height_ff <= out_height_in;
      end
   end

   assign rsp_data = {4'b0000, out_err_ff, out_height_ff, out_width_ff, out_pos_ff,
                      out_value_ff};
   assign rsp_kind = out_kind_ff;
   assign rsp_last = out_last_ff;

endmodule

[src/pcx_ctrl.sv]
// pcx decoder controller: parse phase, run and done sequencing, result handshake
module pcx_ctrl
   import pcx_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   input  logic           req_start,
   output logic           req_tready,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   input  pcx_status_type status,
   output pcx_cmd_type    cmd
);

   typedef enum logic [1:0] {
      S_TAKE,
      S_RUN,
      S_DONE
   } state_type;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_PIXELS,
      PH_MARKER,
      PH_PALETTE,
      PH_IDLE
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in, phase_eff;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;
   logic      accept;

   // output slot is free when empty or being drained
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_TAKE) && slot_free;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign phase_eff  = req_start ? PH_HEADER : phase_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cmd      = '0;
      case (state_ff)
         S_TAKE: begin
            if (accept) begin
               phase_in = phase_eff;
               case (phase_eff)
                  PH_HEADER: begin
                     if (status.sig_bad) begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = KIND_ERROR;
                        cmd.out_err  = ERR_SIGNATURE;
                        cmd.out_last = 1'b1;
                        phase_in     = PH_IDLE;
                     end else if (status.hdr_dim && status.dim_big) begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = KIND_ERROR;
                        cmd.out_err  = ERR_SIZE;
                        cmd.out_last = 1'b1;
                        phase_in     = PH_IDLE;
                     end else begin
                        cmd.hdr_step = 1'b1;
                        if (status.hdr_end) begin
                           cmd.size_load = 1'b1;
                           cmd.out_load  = 1'b1;
                           cmd.out_kind  = KIND_SIZE;
                           cmd.out_last  = 1'b1;
                           phase_in      = PH_PIXELS;
                        end
                     end
                  end
                  PH_PIXELS: begin
                     if (status.run_pending) begin
                        cmd.run_load = 1'b1;
                        if (!status.run_empty) begin
                           state_in = S_RUN;
                        end
                     end else if (status.byte_run) begin
                        cmd.run_arm = 1'b1;
                     end else begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = KIND_PIXEL;
                        cmd.out_last = 1'b1;
                        cmd.pix_step = 1'b1;
                        if (status.pix_end) begin
                           phase_in = PH_MARKER;
                        end
                     end
                  end
                  PH_MARKER: begin
                     if (status.byte_marker) begin
                        cmd.pal_clear = 1'b1;
                        phase_in      = PH_PALETTE;
                     end else begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = KIND_ERROR;
                        cmd.out_err  = ERR_MARKER;
                        cmd.out_last = 1'b1;
                        phase_in     = PH_IDLE;
                     end
                  end
                  PH_PALETTE: begin
                     cmd.out_load = 1'b1;
                     cmd.out_kind = KIND_PALETTE;
                     cmd.pal_step = 1'b1;
                     if (status.pal_end) begin
                        state_in = S_DONE;
                        phase_in = PH_IDLE;
                     end else begin
                        cmd.out_last = 1'b1;
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
         end
         S_RUN: begin
            // one run pixel per free output slot
            if (slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_PIXEL;
               cmd.out_run  = 1'b1;
               cmd.out_last = status.run_tail;
               cmd.pix_step = 1'b1;
               if (status.pix_end) begin
                  phase_in = PH_MARKER;
               end
               if (status.run_tail) begin
                  state_in = S_TAKE;
               end
            end
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_DONE;
               cmd.out_last = 1'b1;
               state_in     = S_TAKE;
            end
         end
         default: begin
            state_in = S_TAKE;
         end
      endcase
   end

   // result valid: set on load, cleared on transfer
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_TAKE;
         phase_ff     <= PH_HEADER;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register loaded while a result is pending");

   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && (phase_ff == PH_IDLE) && !req_start) |-> !cmd.out_load)
      else $error("result produced after error or done without a start");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> (phase_ff == PH_IDLE))
      else $error("done result pending while parse is still active");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_RUN) && cmd.out_load && status.run_tail) |=> (state_ff == S_TAKE))
      else $error("run emission did not end after its last pixel");
`endif

endmodule

[test/tb.sv]
// self-checking stream testbench for the pcx run-length image decoder
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pcx_pkg::*;

   localparam int CYCLE_LIMIT = 20_000_000;
   localparam int LONG_HOLD   = 400;
   localparam int TAIL_CYCLES = 200;
   localparam int HDR_BYTES   = int'(HDR_LAST) + 1;
   localparam int PAL_BYTES   = int'(PAL_LAST) + 1;
   localparam int MAX_PRINTS  = 30;

   // error field reads zero on every result but an error
   localparam err_type NO_ERROR = ERR_SIGNATURE;

   // parser phases of the predictor
   typedef enum logic [2:0] {
      PH_HEADER,
      PH_PIXELS,
      PH_MARKER,
      PH_PALETTE,
      PH_IDLE
   } parse_phase_type;

   // one file byte waiting to be sent
   typedef struct {
      logic [BYTE_W-1:0] data;
      logic              start;
      logic              drain;
      int                gap;
   } file_byte_type;

   // one decoded result as it should appear on the result channel
   typedef struct {
      kind_type          kind;
      logic [BYTE_W-1:0] value;
      logic [POS_W-1:0]  position;
      logic [DIM_W-1:0]  width;
      logic [DIM_W-1:0]  height;
      err_type           err;
      logic              last;
   } decoded_result_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata  = '0;
   logic             req_tuser  = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic [2:0]       rsp_tuser;
   logic             rsp_tlast;

   file_byte_type      file_bytes[$];
   decoded_result_type awaited_results[$];

   // predictor state
   parse_phase_type   phase_q;
   logic [HDR_W-1:0]  hdr_idx_q;
   logic [DIM_W-1:0]  width_q;
   logic [DIM_W-1:0]  height_q;
   logic [CNT_W-1:0]  pix_done_q;
   logic [CNT_W-1:0]  pix_total_q;
   logic              run_armed_q;
   logic [RUN_W-1:0]  run_len_q;
   logic [PAL_W-1:0]  pal_idx_q;

   // stimulus shaping and bookkeeping
   bit  tx_quiet;
   bit  drain_next;
   int  tx_wait;
   int  rx_stall;
   int  rx_mode_left;
   bit  rx_calm;
   bit  long_hold_done;
   int  cycle_count = 0;
   int  failures = 0;
   int  bytes_queued = 0;
   int  random_files = 0;
   int  results_checked = 0;
   int  pixels_seen = 0;
   int  palette_seen = 0;
   int  sizes_seen = 0;
   int  done_seen = 0;
   int  errors_seen = 0;

   pcx_rle_image_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // clock and a single reset at the start
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   task automatic clear_decoder();
      phase_q     = PH_HEADER;
      hdr_idx_q   = '0;
      width_q     = '0;
      height_q    = '0;
      pix_done_q  = '0;
      pix_total_q = '0;
      run_armed_q = 1'b0;
      run_len_q   = '0;
      pal_idx_q   = '0;
   endtask

   task automatic await_result(input kind_type kind, input logic [BYTE_W-1:0] value,
                               input logic [POS_W-1:0] position,
                               input logic [DIM_W-1:0] width,
                               input logic [DIM_W-1:0] height, input err_type err);
      decoded_result_type r;
      r.kind     = kind;
      r.value    = value;
      r.position = position;
      r.width    = width;
      r.height   = height;
      r.err      = err;
      r.last     = 1'b0;
      awaited_results.push_back(r);
   endtask

   // works out the results of one accepted file byte
   task automatic decode_file_byte(input logic [BYTE_W-1:0] b, input logic start);
      logic [FULL_W-1:0] full;
      logic [CNT_W-1:0]  left;
      logic [CNT_W-1:0]  count;
      int                n;
      n = 0;
      if (start) clear_decoder();
      case (phase_q)
         PH_HEADER: begin
            if ((hdr_idx_q == IDX_SIG0 && b != SIG_B0) || (hdr_idx_q == IDX_SIG1 && b != SIG_B1) ||
                (hdr_idx_q == IDX_SIG2 && b != SIG_B2) || (hdr_idx_q == IDX_SIG3 && b != SIG_B3)) begin
               phase_q = PH_IDLE;
               await_result(KIND_ERROR, '0, '0, '0, '0, ERR_SIGNATURE);
               n = 1;
            end else begin
               if (hdr_idx_q == IDX_WLO) width_q = DIM_W'(b);
               if (hdr_idx_q == IDX_HLO) height_q = DIM_W'(b);
               // high byte completes a dimension: maximum plus one
               if (hdr_idx_q == IDX_WHI || hdr_idx_q == IDX_HHI) begin
                  full = FULL_W'((hdr_idx_q == IDX_WHI) ? width_q : height_q)
                         + {1'b0, b, 8'd0} + FULL_W'(1);
                  if (full > FULL_W'(MAX_SIDE)) begin
                     phase_q = PH_IDLE;
                     await_result(KIND_ERROR, '0, '0, '0, '0, ERR_SIZE);
                     n = 1;
                  end else if (hdr_idx_q == IDX_WHI) begin
                     width_q = full[DIM_W-1:0];
                  end else begin
                     height_q = full[DIM_W-1:0];
                  end
               end
               if (n == 0) begin
                  if (hdr_idx_q == HDR_LAST) begin
                     pix_total_q = CNT_W'(width_q) * CNT_W'(height_q);
                     pix_done_q  = '0;
                     run_armed_q = 1'b0;
                     run_len_q   = '0;
                     phase_q     = PH_PIXELS;
                     await_result(KIND_SIZE, '0, '0, width_q, height_q, NO_ERROR);
                     n = 1;
                  end else begin
                     hdr_idx_q = hdr_idx_q + 1'b1;
                  end
               end
            end
         end
         PH_PIXELS: begin
            if (run_armed_q) begin
               // value byte of a run, clipped to the pixels left
               run_armed_q = 1'b0;
               left  = pix_total_q - pix_done_q;
               count = CNT_W'(run_len_q);
               if (count > left) count = left;
               repeat (count) begin
                  await_result(KIND_PIXEL, b, pix_done_q[POS_W-1:0], '0, '0, NO_ERROR);
                  n++;
                  pix_done_q = pix_done_q + 1'b1;
               end
            end else if (b[7:6] == RUN_TAG) begin
               run_len_q   = b[RUN_W-1:0];
               run_armed_q = 1'b1;
            end else begin
               await_result(KIND_PIXEL, b, pix_done_q[POS_W-1:0], '0, '0, NO_ERROR);
               n = 1;
               pix_done_q = pix_done_q + 1'b1;
            end
            if (pix_done_q >= pix_total_q) phase_q = PH_MARKER;
         end
         PH_MARKER: begin
            if (b == PAL_MARKER) begin
               phase_q   = PH_PALETTE;
               pal_idx_q = '0;
            end else begin
               phase_q = PH_IDLE;
               await_result(KIND_ERROR, '0, '0, '0, '0, ERR_MARKER);
               n = 1;
            end
         end
         PH_PALETTE: begin
            await_result(KIND_PALETTE, {2'b00, b[7:2]}, POS_W'(pal_idx_q), '0, '0, NO_ERROR);
            n = 1;
            pal_idx_q = pal_idx_q + 1'b1;
            if (pal_idx_q > PAL_LAST) begin
               await_result(KIND_DONE, '0, '0, '0, '0, NO_ERROR);
               n = 2;
               phase_q = PH_IDLE;
            end
         end
         default: begin
         end
      endcase
      if (n > 0) awaited_results[awaited_results.size() - 1].last = 1'b1;
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         if (failures < MAX_PRINTS)
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (tx_quiet || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   task automatic push_byte(input logic [BYTE_W-1:0] b, input logic start);
      file_byte_type item;
      item.data  = b;
      item.start = start;
      item.drain = drain_next;
      item.gap   = pick_gap();
      drain_next = 1'b0;
      file_bytes.push_back(item);
      bytes_queued++;
   endtask

   // first nbytes of a header holding the given window maxima
   task automatic push_header(input logic start, input logic [15:0] xmax,
                              input logic [15:0] ymax, input int nbytes);
      logic [BYTE_W-1:0] b;
      for (int i = 0; i < nbytes; i++) begin
         case (HDR_W'(i))
            IDX_SIG0: b = SIG_B0;
            IDX_SIG1: b = SIG_B1;
            IDX_SIG2: b = SIG_B2;
            IDX_SIG3: b = SIG_B3;
            IDX_WLO:  b = xmax[7:0];
            IDX_WHI:  b = xmax[15:8];
            IDX_HLO:  b = ymax[7:0];
            IDX_HHI:  b = ymax[15:8];
            default:  b = 8'($urandom);
         endcase
         push_byte(b, start && i == 0);
      end
   endtask

   // run-length data for total pixels; the last run may overshoot and get clipped
   task automatic push_pixels(input int total, input int run_pct);
      int                left;
      int                cnt;
      logic [BYTE_W-1:0] b;
      left = total;
      while (left > 0) begin
         if ($urandom_range(0, 99) < run_pct) begin
            cnt = $urandom_range(0, 63);
            push_byte({RUN_TAG, RUN_W'(cnt)}, 1'b0);
            push_byte(8'($urandom), 1'b0);
            left -= (cnt < left) ? cnt : left;
         end else begin
            b = 8'($urandom);
            if (b[7:6] == RUN_TAG) b[6] = 1'b0;
            push_byte(b, 1'b0);
            left--;
         end
      end
   endtask

   // marker then count palette bytes, led by both extreme byte values
   task automatic push_palette(input int count);
      push_byte(PAL_MARKER, 1'b0);
      for (int i = 0; i < count; i++)
         push_byte((i == 0) ? 8'hFF : (i == 1) ? 8'h00 : 8'($urandom), 1'b0);
   endtask

   // header, pixels and the first pal_bytes of the palette
   task automatic push_file(input logic start, input int w, input int h, input int run_pct,
                            input int pal_bytes);
      push_header(start, 16'(w - 1), 16'(h - 1), HDR_BYTES);
      push_pixels(w * h, run_pct);
      push_palette(pal_bytes);
   endtask

   // signature good up to position k, bad there, then a byte that must be ignored
   task automatic push_bad_signature(input int k);
      logic [BYTE_W-1:0] sig [4];
      sig = '{SIG_B0, SIG_B1, SIG_B2, SIG_B3};
      for (int i = 0; i < k; i++) push_byte(sig[i], i == 0);
      push_byte(sig[k] ^ 8'($urandom_range(1, 255)), k == 0);
      push_byte(SIG_B0, 1'b0);
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= 1'b0;
         tx_wait    <= 0;
      end else if (!req_tvalid || req_tready) begin
         // previous transfer done or none pending: offer the next byte after its gap
         if (file_bytes.size() != 0 && tx_wait >= file_bytes[0].gap &&
             (!file_bytes[0].drain || (!req_tvalid && awaited_results.size() == 0))) begin
            req_tvalid <= 1'b1;
            req_tdata  <= file_bytes[0].data;
            req_tuser  <= file_bytes[0].start;
            tx_wait    <= 0;
            void'(file_bytes.pop_front());
         end else begin
            req_tvalid <= 1'b0;
            if (file_bytes.size() != 0 && tx_wait < file_bytes[0].gap) tx_wait <= tx_wait + 1;
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready     <= 1'b0;
         rx_stall       <= 0;
         rx_calm        <= 1'b0;
         rx_mode_left   <= 0;
         long_hold_done <= 1'b0;
      end else begin
         // alternate calm stretches and busy ones
         if (rx_mode_left == 0) begin
            rx_calm      <= ($urandom_range(0, 3) == 0);
            rx_mode_left <= $urandom_range(50, 400);
         end else begin
            rx_mode_left <= rx_mode_left - 1;
         end
         // one long hold-off once the wide image has started
         if (!long_hold_done && sizes_seen == 2) begin
            rsp_tready     <= 1'b0;
            rx_stall       <= LONG_HOLD;
            long_hold_done <= 1'b1;
         end else if (rx_stall != 0) begin
            rsp_tready <= 1'b0;
            rx_stall   <= rx_stall - 1;
         end else if (rx_calm || $urandom_range(0, 99) < 70) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            rx_stall   <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                       : $urandom_range(6, 25);
         end
      end
   end

   // ---------------------------------------------------------------- scoreboard

   always @(posedge clock) begin
      decoded_result_type want;
      if (reset) begin
         clear_decoder();
      end else begin
         // predict from the accepted byte first
         if (req_tvalid && req_tready) decode_file_byte(req_tdata, req_tuser);
         // check each result transfer against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               if (failures < MAX_PRINTS)
                  $error("unexpected result: kind %0d, tdata %h", rsp_tuser, rsp_tdata);
               failures++;
            end else begin
               want = awaited_results.pop_front();
               compare_field("result_kind", 32'(want.kind), 32'(rsp_tuser));
               compare_field("value", 32'(want.value), 32'(rsp_tdata[7:0]));
               compare_field("position", 32'(want.position), 32'(rsp_tdata[31:8]));
               compare_field("image_width", 32'(want.width), 32'(rsp_tdata[44:32]));
               compare_field("image_height", 32'(want.height), 32'(rsp_tdata[57:45]));
               compare_field("error_code", 32'(want.err), 32'(rsp_tdata[59:58]));
               compare_field("tdata_padding", 32'd0, 32'(rsp_tdata[63:60]));
               compare_field("last", 32'(want.last), 32'(rsp_tlast));
               results_checked++;
               case (want.kind)
                  KIND_PIXEL:   pixels_seen++;
                  KIND_PALETTE: palette_seen++;
                  KIND_SIZE:    sizes_seen++;
                  KIND_DONE:    done_seen++;
                  default:      errors_seen++;
               endcase
            end
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- test sequence

   initial begin
      int choice;
      int w;
      int h;
      int cut;
      logic [15:0] big;

      tx_quiet   = 1'b0;
      drain_next = 1'b0;

      // smallest image straight after reset, no start flag, full palette; then bytes after done
      push_file(1'b0, 1, 1, 0, PAL_BYTES);
      push_byte(SIG_B0, 1'b0);
      push_byte(8'hFF, 1'b0);

      // widest image sent back to back, the receiver holds off meanwhile
      tx_quiet = 1'b1;
      push_file(1'b1, MAX_SIDE, 1, 95, 4);
      tx_quiet = 1'b0;

      // bad signature at each of the four bytes
      for (int k = 0; k < 4; k++) push_bad_signature(k);

      // width and height over the limit, at both ends of the range
      push_header(1'b1, 16'hFFFF, 16'h0000, 10);
      push_byte(8'h00, 1'b0);
      push_header(1'b1, 16'(MAX_SIDE), 16'h0000, 10);
      push_header(1'b1, 16'h0000, 16'(MAX_SIDE), 12);
      push_header(1'b1, 16'h0003, 16'hFFFF, 12);

      // 4x3 image: zero runs, full run, literal, run clipped at the end; then wrong marker
      push_header(1'b1, 16'd3, 16'd2, HDR_BYTES);
      push_byte({RUN_TAG, 6'd0}, 1'b0);
      push_byte(8'h55, 1'b0);
      push_byte({RUN_TAG, 6'd0}, 1'b0);
      push_byte(8'hC7, 1'b0);
      push_byte({RUN_TAG, 6'd3}, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte({RUN_TAG, 6'd63}, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(PAL_MARKER + 8'd1, 1'b0);
      push_byte(PAL_MARKER, 1'b0);

      // restarts: mid header, with a run pending, and inside the palette
      push_header(1'b1, 16'd1, 16'd1, 20);
      push_header(1'b1, 16'd4, 16'd4, HDR_BYTES);
      push_byte(8'h21, 1'b0);
      push_byte({RUN_TAG, 6'd5}, 1'b0);
      push_header(1'b1, 16'd0, 16'd0, HDR_BYTES);
      push_byte(8'h7F, 1'b0);
      push_byte(PAL_MARKER, 1'b0);
      repeat (10) push_byte(8'($urandom), 1'b0);

      // tallest image, cut off after its first rows
      push_header(1'b1, 16'd0, 16'(MAX_SIDE - 1), HDR_BYTES);
      push_pixels(200, 90);

      // random files; the first waits until every result so far has come back
      drain_next = 1'b1;
      repeat (6) begin
         random_files++;
         tx_quiet = ($urandom_range(0, 3) == 0);
         choice   = $urandom_range(0, 99);
         if ($urandom_range(0, 7) == 0) begin
            w = $urandom_range(13, 200);
            h = $urandom_range(1, 2);
         end else begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 12);
         end
         if (choice < 62) begin
            push_file(1'b1, w, h, $urandom_range(0, 60), $urandom_range(1, 8));
         end else if (choice < 70) begin
            push_bad_signature($urandom_range(0, 3));
         end else if (choice < 78) begin
            big = 16'($urandom_range(MAX_SIDE, 16'hFFFF));
            if ($urandom_range(0, 1) == 0) push_header(1'b1, big, 16'(h - 1), HDR_BYTES);
            else push_header(1'b1, 16'(w - 1), big, HDR_BYTES);
         end else if (choice < 88) begin
            push_header(1'b1, 16'(w - 1), 16'(h - 1), HDR_BYTES);
            push_pixels(w * h, 40);
            push_byte(PAL_MARKER ^ 8'($urandom_range(1, 255)), 1'b0);
         end else begin
            // truncated file, cut anywhere before the palette ends
            cut = $urandom_range(0, 2);
            push_header(1'b1, 16'(w - 1), 16'(h - 1), (cut == 0) ? $urandom_range(1, 127)
                                                                 : HDR_BYTES);
            if (cut != 0) push_pixels((w * h) / 2, 30);
            if (cut == 2) begin
               push_pixels(w * h - (w * h) / 2, 30);
               push_byte(PAL_MARKER, 1'b0);
               repeat ($urandom_range(1, 20)) push_byte(8'($urandom), 1'b0);
            end
         end
         // a little noise between files
         repeat ($urandom_range(0, 3)) push_byte(8'($urandom), ($urandom_range(0, 9) == 0));
      end
      tx_quiet = 1'b0;

      // drain: all bytes out, all results back, then a quiet tail
      while (file_bytes.size() != 0 || req_tvalid) @(negedge clock);
      while (awaited_results.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("checked %0d results from %0d file bytes: %0d pixels, %0d palette, %0d sizes",
               results_checked, bytes_queued, pixels_seen, palette_seen, sizes_seen);
      $display("%0d complete files, %0d error results, %0d random files, stalls on both sides",
               done_seen, errors_seen, random_files);
      if (failures == 0 && awaited_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[sim.f]
src/pcx_pkg.sv
src/pcx_dp.sv
src/pcx_ctrl.sv
src/pcx_rle_image_decoder.sv
test/tb.sv
